>>> hw/rtl/time_series_density_histogram_defines.svh
// Assertion macros for the density histogram block.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef TIME_SERIES_DENSITY_HISTOGRAM_DEFINES_SVH
`define TIME_SERIES_DENSITY_HISTOGRAM_DEFINES_SVH
`ifndef SYNTHESIS
`define TSDH_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tsdh check failed");
`define TSDH_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("tsdh forbidden condition");
`else
`define TSDH_ASSERT(lbl, clk, rst_n, prop)
`define TSDH_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

>>> hw/rtl/tsdh_pkg.sv
// Shared constants, operation codes and types of the density histogram.
// No dependencies.
package tsdh_pkg;
  localparam int MaxIntervals = 64;
  localparam int MaxBins      = 64;
  localparam int MaxSeries    = 1024;
  localparam int IvW          = $clog2(MaxIntervals);
  localparam int BnW          = $clog2(MaxBins);
  localparam int CellW        = IvW + BnW;
  localparam int Cells        = MaxIntervals * MaxBins;
  localparam int CntW         = 11;
  localparam int RegW         = 7;
  localparam logic [CntW-1:0] CountMax = 11'd2047;

  localparam logic [1:0] OpClear = 2'd0;
  localparam logic [1:0] OpAdd   = 2'd1;
  localparam logic [1:0] OpRead  = 2'd2;
  localparam logic [1:0] OpNop   = 2'd3;

  localparam logic [1:0] RegIntervals = 2'd0;
  localparam logic [1:0] RegBins      = 2'd1;
  localparam logic [1:0] RegSelAct    = 2'd2;

  typedef struct packed {
    logic [RegW-1:0] num_intervals;
    logic [RegW-1:0] num_bins;
    logic            selection_active;
  } cfg_t;

  // One classified command handed from front to back.
  typedef struct packed {
    logic [1:0]       op;
    logic [CellW-1:0] addr;
    logic [CntW-1:0]  tag;
    logic             sel;
    logic             rd_ok;
  } cmd_t;

  // One cell of both grids.
  typedef struct packed {
    logic [CntW-1:0] fc;
    logic [CntW-1:0] fl;
    logic [CntW-1:0] sc;
    logic [CntW-1:0] sl;
  } word_t;
endpackage

>>> hw/rtl/tsdh_front.sv
// Front end: accepts items, computes interval (serial divider) and bin.
// Depends on tsdh_pkg.
module tsdh_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tsdh_pkg::cfg_t         cfg,
  input  logic                   in_fire,
  input  logic [1:0]             op_in,
  input  logic [9:0]             sid_in,
  input  logic [15:0]            sidx_in,
  input  logic [16:0]            slen_in,
  input  logic [16:0]            sval_in,
  input  logic                   sel_in,
  input  logic [5:0]             ri_in,
  input  logic [5:0]             rb_in,
  output logic                   idle,
  input  logic                   q_full,
  output logic                   q_push,
  output tsdh_pkg::cmd_t         q_data
);
  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_DIV  = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [1:0]  op_r;
  logic [9:0]  sid_r;
  logic [15:0] sidx_r;
  logic [16:0] slen_r;
  logic [16:0] sval_r;
  logic        sel_r;
  logic [5:0]  ri_r, rb_r;
  logic [22:0] rem_r;
  logic [21:0] dvs_r;
  logic [23:0] prodb_r;
  logic [5:0]  quot_r;
  logic [2:0]  step_r;
  logic        sat_r;
  logic        sid_ok;
  logic        ge;
  logic [5:0]  itv;
  logic [5:0]  bin;
  logic [7:0]  bin_raw;

  assign sid_ok = {1'b0, sid_r} < 11'(tsdh_pkg::MaxSeries);
  assign ge     = rem_r >= {1'b0, dvs_r};
  assign idle   = (state_r == F_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r   <= op_in;
      sid_r  <= sid_in;
      sidx_r <= sidx_in;
      slen_r <= slen_in;
      sval_r <= sval_in;
      sel_r  <= sel_in;
      ri_r   <= ri_in;
      rb_r   <= rb_in;
    end
    if (state_r == F_MUL) begin
      rem_r   <= 23'(sidx_r) * 23'(cfg.num_intervals);
      prodb_r <= 24'(sval_r) * 24'(cfg.num_bins);
      dvs_r   <= {slen_r, 5'b0};
      sat_r   <= (slen_r == 17'd0) || ({1'b0, sidx_r} >= slen_r);
      quot_r  <= '0;
      step_r  <= '0;
    end else if (state_r == F_DIV) begin
      if (ge) rem_r <= rem_r - {1'b0, dvs_r};
      dvs_r  <= dvs_r >> 1;
      quot_r <= {quot_r[4:0], ge};
      step_r <= step_r + 3'd1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: if (in_fire) state_nxt = F_MUL;
      F_MUL:  state_nxt = (op_r == tsdh_pkg::OpAdd && sid_ok) ? F_DIV : F_PUSH;
      F_DIV:  if (sat_r || step_r == 3'd5) state_nxt = F_PUSH;
      F_PUSH: if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  assign bin_raw = prodb_r[23:16];
  assign itv = sat_r ? 6'(cfg.num_intervals - 7'd1) : quot_r;
  assign bin = ({1'b0, bin_raw} >= {2'b0, cfg.num_bins}) ?
               6'(cfg.num_bins - 7'd1) : bin_raw[5:0];

  always_comb begin
    q_push = (state_r == F_PUSH) && !q_full;
    q_data.op    = (op_r == tsdh_pkg::OpAdd && !sid_ok) ? tsdh_pkg::OpNop : op_r;
    q_data.tag   = 11'({1'b0, sid_r} + 11'd1);
    q_data.sel   = sel_r;
    q_data.rd_ok = ({1'b0, ri_r} < cfg.num_intervals) && ({1'b0, rb_r} < cfg.num_bins);
    if (op_r == tsdh_pkg::OpRead) q_data.addr = {ri_r, rb_r};
    else                          q_data.addr = {itv, bin};
  end
endmodule

>>> hw/rtl/tsdh_queue.sv
// Two-entry command queue between front and back.
// Depends on tsdh_pkg.
module tsdh_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tsdh_pkg::cmd_t push_data,
  input  logic           pop,
  output tsdh_pkg::cmd_t pop_data,
  output logic           full,
  output logic           empty
);
  tsdh_pkg::cmd_t ent_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_data;
  end
endmodule

>>> hw/rtl/tsdh_back.sv
// Back end: cell memory, read-modify-write of counts, clearing sweep, result register.
// Depends on tsdh_pkg and time_series_density_histogram_defines.svh.
`include "time_series_density_histogram_defines.svh"
module tsdh_back (
  input  logic           clk,
  input  logic           rst_n,
  input  tsdh_pkg::cfg_t cfg,
  input  logic           q_empty,
  input  tsdh_pkg::cmd_t q_data,
  output logic           q_pop,
  output logic           sweeping,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [39:0]    out_tdata
);
  localparam logic [2:0] B_INIT = 3'd0;
  localparam logic [2:0] B_IDLE = 3'd1;
  localparam logic [2:0] B_RD   = 3'd2;
  localparam logic [2:0] B_EXEC = 3'd3;
  localparam logic [2:0] B_RESP = 3'd4;

  localparam int WordW = $bits(tsdh_pkg::word_t);

  logic [WordW-1:0]          mem_q [tsdh_pkg::Cells];
  logic [2:0]                state_r, state_nxt;
  logic [tsdh_pkg::CellW:0]  sweep_r;
  tsdh_pkg::cmd_t            cmd_r;
  tsdh_pkg::word_t           rd_r;
  tsdh_pkg::word_t           upd;
  logic [tsdh_pkg::CntW-1:0] peak_r, peak_nxt;
  logic                      out_tvalid_r;
  logic [39:0]               out_tdata_r, out_tdata_nxt;
  logic                      slot_free;
  logic                      out_load;
  logic                      we, re;
  logic [tsdh_pkg::CellW-1:0] waddr;
  logic [WordW-1:0]          wdata;
  logic [tsdh_pkg::CntW-1:0] fc_o, sc_o, mx_o;
  logic                      vld_o;

  assign slot_free  = !out_tvalid_r || out_tready;
  assign q_pop      = (state_r == B_IDLE) && !q_empty;
  assign sweeping   = (state_r == B_INIT);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Count a series once per cell in the full grid, and in the selection grid when selected; track the peak.
  always_comb begin
    upd      = rd_r;
    peak_nxt = peak_r;
    if (upd.fl != cmd_r.tag) begin
      upd.fl = cmd_r.tag;
      if (upd.fc < tsdh_pkg::CountMax) upd.fc = upd.fc + 11'd1;
    end
    if (cmd_r.sel && upd.sl != cmd_r.tag) begin
      upd.sl = cmd_r.tag;
      if (upd.sc < tsdh_pkg::CountMax) upd.sc = upd.sc + 11'd1;
    end
    if (state_r == B_EXEC && cmd_r.op == tsdh_pkg::OpAdd && upd.fc > peak_r) peak_nxt = upd.fc;
    if (state_r == B_RESP && cmd_r.op == tsdh_pkg::OpClear) peak_nxt = '0;
  end

  always_comb begin
    fc_o  = '0;
    sc_o  = '0;
    vld_o = 1'b0;
    if (state_r == B_EXEC && cmd_r.op == tsdh_pkg::OpRead) begin
      fc_o  = rd_r.fc;
      sc_o  = cfg.selection_active ? rd_r.sc : rd_r.fc;
      vld_o = 1'b1;
    end
    mx_o = (peak_nxt == '0) ? 11'd1 : peak_nxt;
    out_tdata_nxt = {6'b0, vld_o, mx_o, sc_o, fc_o};
    out_load = slot_free && (state_r == B_EXEC || state_r == B_RESP);
  end

  always_comb begin
    re    = (state_r == B_RD);
    we    = (state_r == B_INIT) ||
            (state_r == B_EXEC && slot_free && cmd_r.op == tsdh_pkg::OpAdd);
    waddr = (state_r == B_INIT) ? sweep_r[tsdh_pkg::CellW-1:0] : cmd_r.addr;
    wdata = (state_r == B_INIT) ? '0 : upd;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_INIT: if (sweep_r == (tsdh_pkg::CellW+1)'(tsdh_pkg::Cells - 1)) state_nxt = B_IDLE;
      B_IDLE: begin
        if (q_pop) begin
          if (q_data.op == tsdh_pkg::OpAdd ||
              (q_data.op == tsdh_pkg::OpRead && q_data.rd_ok)) state_nxt = B_RD;
          else state_nxt = B_RESP;
        end
      end
      B_RD:   state_nxt = B_EXEC;
      B_EXEC: if (slot_free) state_nxt = B_IDLE;
      B_RESP: begin
        if (slot_free) state_nxt = (cmd_r.op == tsdh_pkg::OpClear) ? B_INIT : B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_INIT;
      sweep_r      <= '0;
      peak_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      peak_r  <= peak_nxt;
      if (state_r == B_INIT) sweep_r <= sweep_r + 1'b1;
      else                   sweep_r <= '0;
      if (out_load)        out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop)    cmd_r       <= q_data;
    if (out_load) out_tdata_r <= out_tdata_nxt;
    if (we)       mem_q[waddr] <= wdata;
    if (re)       rd_r <= mem_q[cmd_r.addr];
  end

  `TSDH_ASSERT(a_pop_idle, clk, rst_n, q_pop |-> (state_r == B_IDLE))
  `TSDH_NEVER(a_load_busy, clk, rst_n, out_load && out_tvalid_r && !out_tready)
  `TSDH_ASSERT(a_peak_hold, clk, rst_n, (state_r == B_IDLE || state_r == B_RD) |=> $stable(peak_r))
endmodule

>>> hw/rtl/time_series_density_histogram.sv
// Line-density heatmap: one result beat per input beat, in order.
// Path: front multiply, 6-step interval divider for adds (cut short on saturation), queue, back memory access.
// The front takes a new item only after pushing the last one into the queue; the serial interval divider paces adds.
// A clear op sweeps 4096 cells, one per cycle, before the back end takes the next item.
// Reset (rst_n low, synchronous) restores registers to 24/10/0 and runs the same sweep of all 4096 cells.
// Depends on tsdh_pkg, tsdh_front, tsdh_queue, tsdh_back.
module time_series_density_histogram (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // series_id, sample_index, series_length, sample_value, in_selection,
  // interval_index, bin_index (lowest bit up), zero padded
  input  logic [79:0] in_tdata,
  // operation
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // full_count, selected_count, max_count, cell_valid (lowest bit up), zero padded
  output logic [39:0] out_tdata
);
  tsdh_pkg::cfg_t cfg_r;
  tsdh_pkg::cmd_t q_in, q_out;
  logic           front_idle, sweeping, in_fire;
  logic           q_push, q_pop, q_full, q_empty;
  logic [6:0]     clamped;

  // Use zero as one, cap at the grid maximum.
  always_comb begin
    clamped = cfg_data;
    if (cfg_data == 7'd0) clamped = 7'd1;
    if ((cfg_index == tsdh_pkg::RegIntervals) && cfg_data > 7'(tsdh_pkg::MaxIntervals))
      clamped = 7'(tsdh_pkg::MaxIntervals);
    if ((cfg_index == tsdh_pkg::RegBins) && cfg_data > 7'(tsdh_pkg::MaxBins))
      clamped = 7'(tsdh_pkg::MaxBins);
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_intervals    <= 7'd24;
      cfg_r.num_bins         <= 7'd10;
      cfg_r.selection_active <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        tsdh_pkg::RegIntervals: cfg_r.num_intervals    <= clamped;
        tsdh_pkg::RegBins:      cfg_r.num_bins         <= clamped;
        tsdh_pkg::RegSelAct:    cfg_r.selection_active <= cfg_data[0];
        default:      ;
      endcase
    end
  end

  // Hold off input while the front is busy or the cell memory is swept.
  assign in_tready = front_idle && !sweeping;
  assign in_fire   = in_tvalid && in_tready;

  tsdh_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_fire (in_fire),
    .op_in   (in_tuser),
    .sid_in  (in_tdata[9:0]),
    .sidx_in (in_tdata[25:10]),
    .slen_in (in_tdata[42:26]),
    .sval_in (in_tdata[59:43]),
    .sel_in  (in_tdata[60]),
    .ri_in   (in_tdata[66:61]),
    .rb_in   (in_tdata[72:67]),
    .idle    (front_idle),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_in)
  );

  tsdh_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  tsdh_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (q_empty),
    .q_data     (q_out),
    .q_pop      (q_pop),
    .sweeping   (sweeping),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );
endmodule

>>> tb/sv/testbench.sv
// Self-checking bench for the time series density histogram.
// Holds its own model of both grids and the peak count; needs tsdh_pkg and the RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 40000;
  localparam int DrainCycles   = 30;
  localparam int RandomItems   = 1430;

  typedef struct {
    logic [1:0]  op;
    logic [9:0]  sid;
    logic [15:0] sidx;
    logic [16:0] slen;
    logic [16:0] sval;
    logic        sel;
    logic [5:0]  ri;
    logic [5:0]  rb;
  } beat_t;

  typedef struct packed {
    logic [10:0] full;
    logic [10:0] selc;
    logic [10:0] peak;
    logic        valid;
  } cell_report_t;

  // Directed row: typed report used only where known_report is set.
  typedef struct {
    beat_t        b;
    bit           known_report;
    cell_report_t report;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [6:0]  cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic [1:0]  in_tuser = tsdh_pkg::OpNop;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;

  always #1 clk = ~clk;

  time_series_density_histogram i_dut (.*);

  // Shadow state of the block.
  logic [10:0] full_cnt [tsdh_pkg::Cells];
  logic [10:0] full_tag [tsdh_pkg::Cells];
  logic [10:0] sel_cnt  [tsdh_pkg::Cells];
  logic [10:0] sel_tag  [tsdh_pkg::Cells];
  logic [10:0] peak;
  int unsigned n_iv, n_bin;
  bit          sel_on;

  cell_report_t pending_reports[$];
  int  mismatches = 0;
  bit  timed_out = 1'b0;

  function automatic int unsigned clamp_reg(logic [6:0] v, int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return 32'(v);
  endfunction

  function automatic void wipe_grids();
    for (int c = 0; c < tsdh_pkg::Cells; c++) begin
      full_cnt[c] = '0; full_tag[c] = '0; sel_cnt[c] = '0; sel_tag[c] = '0;
    end
    peak = '0;
  endfunction

  // Apply one beat to the shadow grids and return the report it yields.
  function automatic cell_report_t histogram_step(beat_t b);
    cell_report_t r;
    longint unsigned itv, bin;
    int unsigned idx;
    logic [10:0] tag;
    r = '0;
    case (b.op)
      tsdh_pkg::OpClear: wipe_grids();
      tsdh_pkg::OpAdd: begin
        tag = 11'(b.sid) + 11'd1;
        if (b.slen == 0) itv = n_iv - 1;
        else itv = (longint'(b.sidx) * n_iv) / b.slen;
        if (itv >= n_iv) itv = n_iv - 1;
        bin = (longint'(b.sval) * n_bin) >> 16;
        if (bin >= n_bin) bin = n_bin - 1;
        idx = 32'(itv * tsdh_pkg::MaxBins + bin);
        if (full_tag[idx] != tag) begin
          full_tag[idx] = tag;
          if (full_cnt[idx] < tsdh_pkg::CountMax) full_cnt[idx]++;
        end
        if (full_cnt[idx] > peak) peak = full_cnt[idx];
        if (b.sel && sel_tag[idx] != tag) begin
          sel_tag[idx] = tag;
          if (sel_cnt[idx] < tsdh_pkg::CountMax) sel_cnt[idx]++;
        end
      end
      tsdh_pkg::OpRead: begin
        if (b.ri < n_iv && b.rb < n_bin) begin
          idx = b.ri * tsdh_pkg::MaxBins + b.rb;
          r.valid = 1'b1;
          r.full = full_cnt[idx];
          r.selc = sel_on ? sel_cnt[idx] : full_cnt[idx];
        end
      end
      default: ;
    endcase
    r.peak = (peak == 0) ? 11'd1 : peak;
    return r;
  endfunction

  // Receiver stall pattern: rotate between always ready, coin toss and sparse ready.
  int unsigned stall_phase = 0;
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    case ((stall_phase / 300) % 3)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      default: out_tready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  // Compare each result beat with the oldest pending report.
  always @(posedge clk) begin
    cell_report_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got.full = out_tdata[10:0];
      got.selc = out_tdata[21:11];
      got.peak = out_tdata[32:22];
      got.valid = out_tdata[33];
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", out_tdata);
      end else begin
        want = pending_reports.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: full %0d/%0d sel %0d/%0d max %0d/%0d valid %0b/%0b (exp/act)",
                     want.full, got.full, want.selc, got.selc, want.peak, got.peak,
                     want.valid, got.valid);
        end
      end
    end
  end

  // Watchdog: count cycles with no beat on any channel.
  int unsigned quiet = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WatchdogLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("time_series_density_histogram test failed");
      $finish;
    end
  end

  int unsigned burst_left = 0;

  // Send one beat; keep tvalid high across a burst, drop it only for a real gap.
  task automatic send_beat(beat_t b, bit known, cell_report_t typed);
    cell_report_t pred;
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tuser  <= b.op;
    in_tdata  <= {7'd0, b.rb, b.ri, b.sel, b.sval, b.slen, b.sidx, b.sid};
    do @(posedge clk); while (!(in_tvalid && in_tready));
    pred = histogram_step(b);
    pending_reports = {pending_reports, (known ? typed : pred)};
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      burst_left = $urandom_range(1, 30);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Hold the sender until every report has come, then let the block settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [6:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    case (idx)
      tsdh_pkg::RegIntervals: n_iv = clamp_reg(val, tsdh_pkg::MaxIntervals);
      tsdh_pkg::RegBins:      n_bin = clamp_reg(val, tsdh_pkg::MaxBins);
      tsdh_pkg::RegSelAct:    sel_on = val[0];
      default: ;
    endcase
  endtask

  task automatic set_grid(logic [6:0] iv, logic [6:0] bn, logic [6:0] sa);
    write_reg(tsdh_pkg::RegIntervals, iv);
    write_reg(tsdh_pkg::RegBins, bn);
    write_reg(tsdh_pkg::RegSelAct, sa);
  endtask

  function automatic beat_t blank_beat(logic [1:0] op);
    beat_t b;
    b = '{op: op, sid: '0, sidx: '0, slen: 17'd1, sval: '0, sel: 1'b0, ri: '0, rb: '0};
    return b;
  endfunction

  function automatic beat_t add_beat(int unsigned sid, int unsigned sidx, int unsigned slen,
                                     int unsigned sval, bit sel);
    beat_t b;
    b = blank_beat(tsdh_pkg::OpAdd);
    b.sid = 10'(sid); b.sidx = 16'(sidx); b.slen = 17'(slen); b.sval = 17'(sval);
    b.sel = sel;
    return b;
  endfunction

  function automatic beat_t read_beat(int unsigned ri, int unsigned rb);
    beat_t b;
    b = blank_beat(tsdh_pkg::OpRead);
    b.ri = 6'(ri); b.rb = 6'(rb);
    return b;
  endfunction

  function automatic beat_t read_somewhere();
    return read_beat($urandom_range(0, (n_iv + 1 > 63) ? 63 : n_iv + 1),
                     $urandom_range(0, (n_bin + 1 > 63) ? 63 : n_bin + 1));
  endfunction

  // Random series: a run of samples of one id with random content.
  int unsigned run_left = 0, run_sid, run_len;
  bit          run_sel;

  function automatic beat_t next_random_beat();
    beat_t b;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (run_left != 0 && pick < 75) begin
      run_left--;
      return add_beat(run_sid, $urandom_range(0, run_len - 1), run_len,
                      ($urandom_range(0, 20) == 0) ? $urandom_range(65536, 131071)
                                                   : $urandom_range(0, 65536),
                      run_sel);
    end
    if (pick < 80) begin
      // start a new series; mostly short ones, a few very long
      run_sid = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 40);
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 65536) : $urandom_range(1, 64);
      run_sel = 1'($urandom_range(0, 1));
      run_left = $urandom_range(1, 12);
      return read_somewhere();
    end
    if (pick < 95) return read_somewhere();
    if (pick < 99) begin
      // noise: every field random, clear replaced by no operation
      b.op = 2'($urandom_range(1, 3));
      b.sid = 10'($urandom); b.sidx = 16'($urandom); b.slen = 17'($urandom);
      b.sval = 17'($urandom);
      b.sel = 1'($urandom); b.ri = 6'($urandom); b.rb = 6'($urandom);
      return b;
    end
    return blank_beat(($urandom_range(0, 2) == 0) ? tsdh_pkg::OpClear : tsdh_pkg::OpNop);
  endfunction

  row_t directed[$];

  initial begin
    cell_report_t none;
    none = '0;
    wipe_grids();
    n_iv = 24; n_bin = 10; sel_on = 1'b0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: fresh grid reads, field extremes, every operation, clamps.
    directed = '{
      '{read_beat(0, 0),   1'b1, '{11'd0, 11'd0, 11'd1, 1'b1}},
      '{read_beat(23, 9),  1'b1, '{11'd0, 11'd0, 11'd1, 1'b1}},
      '{read_beat(24, 0),  1'b1, '{11'd0, 11'd0, 11'd1, 1'b0}},
      '{read_beat(63, 63), 1'b1, '{11'd0, 11'd0, 11'd1, 1'b0}},
      '{blank_beat(tsdh_pkg::OpNop), 1'b1, '{11'd0, 11'd0, 11'd1, 1'b0}},
      '{add_beat(0, 0, 1, 0, 1'b1),                   1'b1, '{11'd0, 11'd0, 11'd1, 1'b0}},
      '{read_beat(0, 0),                              1'b0, none},
      '{add_beat(1023, 65535, 131071, 131071, 1'b1),  1'b0, none},
      '{add_beat(5, 100, 0, 65536, 1'b0),             1'b0, none},
      '{add_beat(5, 65535, 3, 32768, 1'b0),           1'b0, none},
      '{add_beat(6, 65535, 65536, 65535, 1'b1),       1'b0, none},
      '{add_beat(6, 0, 65536, 65535, 1'b1),           1'b0, none},
      '{add_beat(7, 12, 24, 32768, 1'b0),             1'b0, none},
      '{add_beat(8, 12, 24, 32768, 1'b1),             1'b0, none},
      '{add_beat(7, 12, 24, 32768, 1'b0),             1'b0, none},
      '{read_beat(12, 5),                             1'b0, none},
      '{read_beat(23, 9),                             1'b0, none},
      '{read_beat(22, 9),                             1'b0, none},
      '{blank_beat(tsdh_pkg::OpClear), 1'b1, '{11'd0, 11'd0, 11'd1, 1'b0}},
      '{read_beat(12, 5),    1'b1, '{11'd0, 11'd0, 11'd1, 1'b1}}
    };
    foreach (directed[k]) send_beat(directed[k].b, directed[k].known_report, directed[k].report);

    // Random phases across several grid settings, extremes included.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_grid(7'd1, 7'd1, 7'd1);
        1: set_grid(7'd64, 7'd64, 7'd0);
        2: set_grid(7'd0, 7'd0, 7'd1);
        3: set_grid(7'd127, 7'd127, 7'd127);
        4: set_grid(7'd37, 7'd5, 7'd0);
        default: set_grid(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                          7'($urandom));
      endcase
      for (int k = 0; k < RandomItems / 6; k++) begin
        send_beat(next_random_beat(), 1'b0, none);
        if (phase == 4 && k == 100) drain();
      end
    end

    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("time_series_density_histogram test passed");
    end else begin
      $display("time_series_density_histogram test failed");
    end
    $finish;
  end
endmodule

>>> time_series_density_histogram.f
+incdir+hw/rtl
hw/rtl/tsdh_pkg.sv
hw/rtl/tsdh_front.sv
hw/rtl/tsdh_queue.sv
hw/rtl/tsdh_back.sv
hw/rtl/time_series_density_histogram.sv
tb/sv/testbench.sv
